// ===== src/mvn_pkg.sv =====
// shared types and codes of the mesh vertex normal unit
package mvn_pkg;

  localparam int CoordW = 16;
  localparam int NormW  = 16;
  localparam int VtxW   = 6;

  // request kinds
  localparam logic [1:0] KIND_WR_POS  = 2'd0;
  localparam logic [1:0] KIND_WR_IDX  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_STRIP_MODE   = 2'd0;
  localparam logic [1:0] CFG_USE_INDICES  = 2'd1;
  localparam logic [1:0] CFG_VERTEX_COUNT = 2'd2;
  localparam logic [1:0] CFG_INDEX_COUNT  = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic [7:0]               slot;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [VtxW-1:0]          index_value;
  } in_req_t;

  typedef struct packed {
    logic [VtxW-1:0]         vertex;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic                    degenerate;
    logic                    last;
  } out_req_t;

  // result of the normalising unit
  typedef struct packed {
    logic signed [NormW-1:0] x;
    logic signed [NormW-1:0] y;
    logic signed [NormW-1:0] z;
    logic                    zero;
  } norm_res_t;

endpackage

// ===== src/mvn_ram.sv =====
// generic single write port ram with registered read
module mvn_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mvn_norm.sv =====
// multi-cycle vector normaliser to signed q1.14
module mvn_norm #(
  parameter int W = 44
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [W-1:0]  vec_i [3],
  output logic                 done_o,
  output mvn_pkg::norm_res_t   res_o
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DINIT = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  logic [2:0]   st_q, st_d;
  logic [4:0]   cnt_q, cnt_d;
  logic [1:0]   comp_q, comp_d;
  logic         done_q, done_d;
  logic [W-1:0] mag_q [3];
  logic [W-1:0] mag_d [3];
  logic [W-1:0] mx_q, mx_d;
  logic [2:0]   neg_q, neg_d;
  logic [59:0]  prod_q, prod_d;
  logic [61:0]  len_q, len_d;
  logic [31:0]  rem_q, rem_d;
  logic [30:0]  root_q, root_d;
  logic [31:0]  drem_q, drem_d;
  logic [14:0]  dnum_q, dnum_d;
  logic [14:0]  quo_q, quo_d;
  mvn_pkg::norm_res_t res_q, res_d;

  logic [W-1:0] mag_in [3];
  logic [W-1:0] mx_in;
  logic [29:0]  sq_op;
  logic [33:0]  sq_r2, sq_trial;
  logic [44:0]  num;
  logic [29:0]  div_op;
  logic [32:0]  div_r2;
  logic         qbit;
  logic [14:0]  quo_n, quo_c;
  logic signed [15:0] comp_val;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec_i[i][W-1] ? W'(-vec_i[i]) : W'(vec_i[i]);
    end
    mx_in = mag_in[0];
    if (mag_in[1] > mx_in) mx_in = mag_in[1];
    if (mag_in[2] > mx_in) mx_in = mag_in[2];
  end

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sq_op = mag_q[0][29:0];
      2'd1:    sq_op = mag_q[1][29:0];
      default: sq_op = mag_q[2][29:0];
    endcase
    case (comp_q)
      2'd0:    div_op = mag_q[0][29:0];
      2'd1:    div_op = mag_q[1][29:0];
      default: div_op = mag_q[2][29:0];
    endcase
  end

  assign sq_r2    = {rem_q, len_q[61:60]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign num      = {1'b0, div_op, 14'd0} + 45'(root_q[30:1]);
  assign div_r2   = {drem_q, dnum_q[14]};
  assign qbit     = div_r2 >= {2'b00, root_q};
  assign quo_n    = {quo_q[13:0], qbit};
  assign quo_c    = (quo_n > 15'd16384) ? 15'd16384 : quo_n;
  assign comp_val = neg_q[comp_q] ? -$signed({1'b0, quo_c}) : $signed({1'b0, quo_c});

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    comp_d = comp_q;
    done_d = 1'b0;
    mag_d  = mag_q;
    mx_d   = mx_q;
    neg_d  = neg_q;
    prod_d = prod_q;
    len_d  = len_q;
    rem_d  = rem_q;
    root_d = root_q;
    drem_d = drem_q;
    dnum_d = dnum_q;
    quo_d  = quo_q;
    res_d  = res_q;
    case (st_q)
      N_IDLE: begin
        if (start_i) begin
          mag_d = mag_in;
          mx_d  = mx_in;
          neg_d = {vec_i[2][W-1], vec_i[1][W-1], vec_i[0][W-1]};
          if (mx_in == '0) begin
            res_d  = '{x: '0, y: '0, z: '0, zero: 1'b1};
            done_d = 1'b1;
          end else begin
            res_d.zero = 1'b0;
            st_d = N_SHIFT;
          end
        end
      end
      N_SHIFT: begin
        // bring the largest magnitude into [2^29, 2^30)
        if (|mx_q[W-1:30]) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
          mx_d = mx_q >> 1;
        end else if (!mx_q[29]) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
          mx_d = mx_q << 1;
        end else begin
          cnt_d = '0;
          len_d = '0;
          st_d  = N_SQ;
        end
      end
      N_SQ: begin
        if (cnt_q != 5'd3) prod_d = sq_op * sq_op;
        if (cnt_q != 5'd0) len_d = len_q + 62'(prod_q);
        if (cnt_q == 5'd3) begin
          cnt_d  = '0;
          rem_d  = '0;
          root_d = '0;
          st_d   = N_SQRT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      N_SQRT: begin
        // two radicand bits per cycle
        len_d = len_q << 2;
        if (sq_r2 >= sq_trial) begin
          rem_d  = 32'(sq_r2 - sq_trial);
          root_d = {root_q[29:0], 1'b1};
        end else begin
          rem_d  = sq_r2[31:0];
          root_d = {root_q[29:0], 1'b0};
        end
        if (cnt_q == 5'd30) begin
          comp_d = '0;
          st_d   = N_DINIT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      N_DINIT: begin
        // quotient stays below 2^15 since each magnitude is at most the root
        drem_d = {2'b00, num[44:15]};
        dnum_d = num[14:0];
        quo_d  = '0;
        cnt_d  = '0;
        st_d   = N_DIV;
      end
      N_DIV: begin
        drem_d = qbit ? 32'(div_r2 - {2'b00, root_q}) : div_r2[31:0];
        dnum_d = dnum_q << 1;
        quo_d  = quo_n;
        if (cnt_q == 5'd14) begin
          case (comp_q)
            2'd0:    res_d.x = comp_val;
            2'd1:    res_d.y = comp_val;
            default: res_d.z = comp_val;
          endcase
          if (comp_q == 2'd2) begin
            done_d = 1'b1;
            st_d   = N_IDLE;
          end else begin
            comp_d = comp_q + 2'd1;
            st_d   = N_DINIT;
          end
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      default: st_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= N_IDLE;
      cnt_q  <= '0;
      comp_q <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      comp_q <= comp_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    mx_q   <= mx_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    drem_q <= drem_d;
    dnum_q <= dnum_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_done_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(st_q) == N_DIV || $past(st_q) == N_IDLE))
    else $error("normaliser done without work");
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.zero) |-> (res_q.x == 0 && res_q.y == 0 && res_q.z == 0))
    else $error("zero vector with nonzero result");
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == N_DINIT) |-> root_q[30:29] != 2'b00)
    else $error("root below 2^29");
`endif

endmodule

// ===== src/mesh_vertex_normal_calc.sv =====
// averaged vertex normal unit: position and index stores, face walk, normaliser
// Load requests (kind 0 position, kind 1 index) are taken one per cycle while the block is
// idle and write the position or index ram directly. A compute request (kind 2) stalls the
// input while the block gives one unit normal per vertex 0 .. vertex_count-1, last set on
// the final one. For each vertex every triangle is walked: an indexed triangle reads its
// three corners from the index ram and tests them (non-indexed corners are the slot numbers
// themselves); a triangle that uses the vertex then reads its positions and forms the cross
// product on one shared 17x17 multiplier, plus one normaliser pass in strip and non-indexed
// list modes. Each vertex ends with one more normaliser pass. The run time is set by the
// per-triangle walk and the iterative normaliser (shift, square sum, square root, three
// divisions on one divider). A result sits in an output register, so the walk of the next
// vertex overlaps a stalled output. Reading a position or index slot never written gives
// undefined normals. Configuration is to be written only while the block is idle; the
// block itself does not enforce this.
module mesh_vertex_normal_calc #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_INDICES  = 192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mvn_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mvn_pkg::out_req_t  out_req_o
);

  localparam int MaxSpan = (MAX_INDICES > MAX_VERTICES) ? MAX_INDICES : MAX_VERTICES;
  localparam int PW      = ($clog2(MaxSpan + 4) < 9) ? 9 : $clog2(MaxSpan + 4);
  localparam int VAW     = $clog2(MAX_VERTICES);
  localparam int IAW     = $clog2(MAX_INDICES);
  localparam int FW      = 35;
  localparam int SumW    = 36 + $clog2(MAX_INDICES);
  localparam int PosW    = 3 * mvn_pkg::CoordW;

  // walk sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TRI   = 4'd1;
  localparam logic [3:0] S_IRD   = 4'd2;
  localparam logic [3:0] S_ICAP  = 4'd3;
  localparam logic [3:0] S_MEMB  = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_PCAP  = 4'd6;
  localparam logic [3:0] S_EDGE  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_ACC   = 4'd9;
  localparam logic [3:0] S_FGO   = 4'd10;
  localparam logic [3:0] S_FWAIT = 4'd11;
  localparam logic [3:0] S_VGO   = 4'd12;
  localparam logic [3:0] S_VWAIT = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;
  localparam logic [3:0] S_FADD  = 4'd15;

  // configuration
  logic       strip_q, uidx_q;
  logic [6:0] vcnt_q;
  logic [7:0] icnt_q;

  // sequencer
  logic [3:0]    st_q, st_d;
  logic [1:0]    k_q, k_d;
  logic [2:0]    j_q, j_d;
  logic [6:0]    vtx_q, vtx_d;
  logic [6:0]    nv_q, nv_d;
  logic [PW-1:0] base_q, base_d;
  logic          out_valid_q, out_valid_d;
  mvn_pkg::out_req_t out_q, out_d;

  // walk data
  logic [5:0]             corner_q [3];
  logic [5:0]             corner_d [3];
  logic [PosW-1:0]        pos_q [3];
  logic [PosW-1:0]        pos_d [3];
  logic signed [16:0]     e1_q [3];
  logic signed [16:0]     e1_d [3];
  logic signed [16:0]     e2_q [3];
  logic signed [16:0]     e2_d [3];
  logic signed [33:0]     prod_q, prod_d;
  logic signed [FW-1:0]   f_q [3];
  logic signed [FW-1:0]   f_d [3];
  logic signed [SumW-1:0] sum_q [3];
  logic signed [SumW-1:0] sum_d [3];

  logic          in_acc;
  logic [6:0]    nv_cfg;
  logic [PW-1:0] ni_cfg, span;
  logic          unit_faces, odd, tri_ok, hit, in_range;
  logic [PW-1:0] cpos [3];
  logic [PW-1:0] step;
  logic signed [16:0] mul_a, mul_b;
  logic [PosW-1:0] pos_rdata;
  logic [5:0]      idx_rdata;
  logic            norm_start, norm_done;
  logic signed [SumW-1:0] norm_vec [3];
  logic signed [15:0]     norm_c [3];
  mvn_pkg::norm_res_t     norm_res;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = st_q != S_IDLE;

  // saturated counts
  assign nv_cfg = (vcnt_q > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcnt_q;
  assign ni_cfg = (PW'(icnt_q) > PW'(MAX_INDICES)) ? PW'(MAX_INDICES) : PW'(icnt_q);
  assign span   = uidx_q ? ni_cfg : PW'(nv_q);
  assign unit_faces = strip_q || !uidx_q;

  // corner slots of the current triangle; odd strip triangles swap the first two
  assign odd  = strip_q && base_q[0];
  assign step = strip_q ? PW'(1) : PW'(3);
  always_comb begin
    cpos[0] = base_q + (odd ? PW'(1) : PW'(0));
    cpos[1] = base_q + (strip_q ? (odd ? PW'(0) : PW'(1)) : PW'(1));
    cpos[2] = base_q + PW'(2);
  end
  assign tri_ok = cpos[2] < span;

  assign hit = ({1'b0, corner_q[0]} == vtx_q) || ({1'b0, corner_q[1]} == vtx_q) ||
               ({1'b0, corner_q[2]} == vtx_q);
  // corners beyond the position store read as the origin
  assign in_range = {1'b0, corner_q[k_q]} < 7'(MAX_VERTICES);

  // cross product term order: y*z, z*y, z*x, x*z, x*y, y*x
  always_comb begin
    case (j_q)
      3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
      3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
      3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
      3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
      3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
      default: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
    endcase
  end

  // normaliser gets the face in face mode, the vertex sum at the end of a vertex
  assign norm_start = (st_q == S_FGO) || (st_q == S_VGO);
  assign norm_c[0]  = norm_res.x;
  assign norm_c[1]  = norm_res.y;
  assign norm_c[2]  = norm_res.z;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      norm_vec[a] = (st_q == S_VGO) ? sum_q[a] : SumW'(f_q[a]);
    end
  end

  mvn_ram #(.Width(PosW), .Depth(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && in_req_i.kind == mvn_pkg::KIND_WR_POS &&
              32'(in_req_i.slot) < MAX_VERTICES),
    .waddr_i (VAW'(in_req_i.slot)),
    .wdata_i ({in_req_i.pos_x, in_req_i.pos_y, in_req_i.pos_z}),
    .raddr_i (VAW'(corner_q[k_q])),
    .rdata_o (pos_rdata)
  );

  mvn_ram #(.Width(6), .Depth(MAX_INDICES)) u_idx_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && in_req_i.kind == mvn_pkg::KIND_WR_IDX &&
              32'(in_req_i.slot) < MAX_INDICES),
    .waddr_i (IAW'(in_req_i.slot)),
    .wdata_i (in_req_i.index_value),
    .raddr_i (IAW'(cpos[k_q])),
    .rdata_o (idx_rdata)
  );

  mvn_norm #(.W(SumW)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_i   (norm_vec),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

  always_comb begin
    st_d        = st_q;
    k_d         = k_q;
    j_d         = j_q;
    vtx_d       = vtx_q;
    nv_d        = nv_q;
    base_d      = base_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    corner_d    = corner_q;
    pos_d       = pos_q;
    e1_d        = e1_q;
    e2_d        = e2_q;
    prod_d      = prod_q;
    f_d         = f_q;
    sum_d       = sum_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (in_acc && in_req_i.kind == mvn_pkg::KIND_COMPUTE && nv_cfg != 7'd0) begin
          nv_d   = nv_cfg;
          vtx_d  = '0;
          base_d = '0;
          for (int a = 0; a < 3; a++) sum_d[a] = '0;
          st_d   = S_TRI;
        end
      end
      S_TRI: begin
        if (tri_ok) begin
          k_d = '0;
          if (uidx_q) begin
            st_d = S_IRD;
          end else begin
            for (int c = 0; c < 3; c++) corner_d[c] = cpos[c][5:0];
            st_d = S_MEMB;
          end
        end else begin
          st_d = S_VGO;
        end
      end
      S_IRD: st_d = S_ICAP;
      S_ICAP: begin
        corner_d[k_q] = idx_rdata;
        if (k_q == 2'd2) begin
          k_d  = '0;
          st_d = S_MEMB;
        end else begin
          k_d  = k_q + 2'd1;
          st_d = S_IRD;
        end
      end
      S_MEMB: begin
        if (hit) begin
          st_d = S_PRD;
        end else begin
          base_d = base_q + step;
          st_d   = S_TRI;
        end
      end
      S_PRD: st_d = S_PCAP;
      S_PCAP: begin
        pos_d[k_q] = in_range ? pos_rdata : '0;
        if (k_q == 2'd2) begin
          k_d  = '0;
          st_d = S_EDGE;
        end else begin
          k_d  = k_q + 2'd1;
          st_d = S_PRD;
        end
      end
      S_EDGE: begin
        for (int a = 0; a < 3; a++) begin
          e1_d[a] = 17'($signed(pos_q[1][PosW-1-16*a -: 16])) -
                    17'($signed(pos_q[0][PosW-1-16*a -: 16]));
          e2_d[a] = 17'($signed(pos_q[2][PosW-1-16*a -: 16])) -
                    17'($signed(pos_q[0][PosW-1-16*a -: 16]));
          f_d[a]  = '0;
        end
        j_d  = '0;
        st_d = S_MUL;
      end
      S_MUL: begin
        prod_d = mul_a * mul_b;
        st_d   = S_ACC;
      end
      S_ACC: begin
        if (j_q[0]) f_d[j_q[2:1]] = f_q[j_q[2:1]] - FW'(prod_q);
        else        f_d[j_q[2:1]] = f_q[j_q[2:1]] + FW'(prod_q);
        if (j_q == 3'd5) begin
          st_d = unit_faces ? S_FGO : S_FADD;
        end else begin
          j_d  = j_q + 3'd1;
          st_d = S_MUL;
        end
      end
      S_FADD: begin
        for (int a = 0; a < 3; a++) sum_d[a] = sum_q[a] + SumW'(f_q[a]);
        base_d = base_q + step;
        st_d   = S_TRI;
      end
      S_FGO: st_d = S_FWAIT;
      S_FWAIT: begin
        if (norm_done) begin
          for (int a = 0; a < 3; a++) sum_d[a] = sum_q[a] + SumW'(norm_c[a]);
          base_d = base_q + step;
          st_d   = S_TRI;
        end
      end
      S_VGO: st_d = S_VWAIT;
      S_VWAIT: begin
        if (norm_done) st_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.vertex     = vtx_q[5:0];
          out_d.normal_x   = norm_res.x;
          out_d.normal_y   = norm_res.y;
          out_d.normal_z   = norm_res.z;
          out_d.degenerate = norm_res.zero;
          out_d.last       = (vtx_q + 7'd1) == nv_q;
          if ((vtx_q + 7'd1) == nv_q) begin
            st_d = S_IDLE;
          end else begin
            vtx_d  = vtx_q + 7'd1;
            base_d = '0;
            for (int a = 0; a < 3; a++) sum_d[a] = '0;
            st_d   = S_TRI;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q     <= 1'b0;
      uidx_q      <= 1'b1;
      vcnt_q      <= '0;
      icnt_q      <= '0;
      st_q        <= S_IDLE;
      k_q         <= '0;
      j_q         <= '0;
      vtx_q       <= '0;
      nv_q        <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mvn_pkg::CFG_STRIP_MODE:   strip_q <= cfg_data_i[0];
          mvn_pkg::CFG_USE_INDICES:  uidx_q  <= cfg_data_i[0];
          mvn_pkg::CFG_VERTEX_COUNT: vcnt_q  <= cfg_data_i[6:0];
          mvn_pkg::CFG_INDEX_COUNT:  icnt_q  <= cfg_data_i;
          default: ;
        endcase
      end
      st_q        <= st_d;
      k_q         <= k_d;
      j_q         <= j_d;
      vtx_q       <= vtx_d;
      nv_q        <= nv_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    corner_q <= corner_d;
    pos_q    <= pos_d;
    e1_q     <= e1_d;
    e2_q     <= e2_d;
    prod_q   <= prod_d;
    f_q      <= f_d;
    sum_q    <= sum_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.degenerate) |->
      (out_req_o.normal_x == 0 && out_req_o.normal_y == 0 && out_req_o.normal_z == 0))
    else $error("degenerate normal not zero");
  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_done |-> (st_q == S_FWAIT || st_q == S_VWAIT))
    else $error("normaliser finished outside a wait");
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EMIT && !out_valid_q) |=> out_valid_q)
    else $error("free output register not loaded");
  a_last_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.last) |-> out_req_o.vertex == 6'(nv_q - 7'd1))
    else $error("last flag on wrong vertex");
`endif

endmodule
